[rtl/bqd_pkg.sv]
package bqd_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 30;

   localparam int COEF_WIDTH  = 32;
   localparam int Y_WIDTH     = 32;
   localparam int RATIO_WIDTH = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DECIM_RATIO = 3'd0,
      REG_COEF_B0     = 3'd1,
      REG_COEF_B1     = 3'd2,
      REG_COEF_B2     = 3'd3,
      REG_COEF_A1     = 3'd4,
      REG_COEF_A2     = 3'd5
   } csr_reg_type;

   localparam logic [RATIO_WIDTH-1:0] RATIO_RST = 8'd10;
   // counter starts two below the reset ratio
   localparam logic [RATIO_WIDTH-1:0] COUNT_RST = RATIO_RST - 8'd2;

   // ratio-10 butterworth lowpass, q2.30
   localparam logic signed [COEF_WIDTH-1:0] B0_RST = 32'sd21564354;
   localparam logic signed [COEF_WIDTH-1:0] B1_RST = 32'sd43128699;
   localparam logic signed [COEF_WIDTH-1:0] B2_RST = 32'sd21564354;
   localparam logic signed [COEF_WIDTH-1:0] A1_RST = -32'sd1676130400;
   localparam logic signed [COEF_WIDTH-1:0] A2_RST = 32'sd688645974;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

endpackage

[rtl/biquad_lowpass_decimator.sv]
// biquad_lowpass_decimator: one direct-form-I second-order section followed
// by a decimator.
// req channel: req_valid / req_stall carry one signed sample per beat.
// rsp channel: rsp_valid / rsp_stall carry one filtered, rounded and
// saturated sample for every decim_ratio input beats (every beat when the
// ratio is zero or one).
// csr port: csr_write with csr_index selects ratio (0) or b0, b1, b2, a1, a2
// (1 to 5); other indexes are dropped. Write only while the block is idle.
// An accepted beat lands in the input register; once it advances, the
// section runs on it and an emitting result is registered, raising rsp_valid.
// Throughput: one beat per cycle, save when an emitting beat waits on a
// stalled output; the y1 feedback runs through the a1 multiply, the sum and
// the clamp with no register between.
// Reset clears the filter history, loads the ratio-10 lowpass coefficients,
// sets the ratio to 10 and the counter to 8, so the second beat after reset
// produces the first result.
// When rsp_stall holds a result, non-emitting beats keep flowing; a beat
// that would emit waits in the input register and req_stall rises.
module biquad_lowpass_decimator #(
   parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   input  logic                               csr_write,
   input  logic [bqd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bqd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bqd_pkg::*;

   logic [RATIO_WIDTH-1:0] ratio_ff, ratio_in;
   coef_set_type           coef_ff, coef_in;
   logic [RATIO_WIDTH-1:0] cnt_ff, cnt_in;

   logic                           xv_ff, xv_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           rv_ff, rv_in;
   logic signed [SAMPLE_WIDTH-1:0] ro_ff;

   logic [RATIO_WIDTH:0]           cnt_next;
   logic                           emit, adv, req_take;
   logic signed [SAMPLE_WIDTH-1:0] sec_sample;

   bqd_section #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_section (
      .clock   (clock),
      .reset   (reset),
      .advance (adv),
      .x       (x_ff),
      .coefs   (coef_ff),
      .sample  (sec_sample)
   );

   // config decode
   always_comb begin
      ratio_in = ratio_ff;
      coef_in  = coef_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DECIM_RATIO: ratio_in   = csr_wdata[RATIO_WIDTH-1:0];
            REG_COEF_B0:     coef_in.b0 = csr_wdata[COEF_WIDTH-1:0];
            REG_COEF_B1:     coef_in.b1 = csr_wdata[COEF_WIDTH-1:0];
            REG_COEF_B2:     coef_in.b2 = csr_wdata[COEF_WIDTH-1:0];
            REG_COEF_A1:     coef_in.a1 = csr_wdata[COEF_WIDTH-1:0];
            REG_COEF_A2:     coef_in.a2 = csr_wdata[COEF_WIDTH-1:0];
            default:         ;
         endcase
      end
   end

   assign cnt_next = {1'b0, cnt_ff} + 9'd1;
   assign emit     = cnt_next >= {1'b0, ratio_ff};

   // the held beat moves on unless it emits into a full, stalled output
   assign adv       = xv_ff && (!emit || !rv_ff || !rsp_stall);
   assign req_stall = xv_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      xv_in = xv_ff;
      if (req_take) begin
         xv_in = 1'b1;
      end else if (adv) begin
         xv_in = 1'b0;
      end

      rv_in = rv_ff;
      if (adv && emit) begin
         rv_in = 1'b1;
      end else if (!rsp_stall) begin
         rv_in = 1'b0;
      end

      cnt_in = cnt_ff;
      if (adv) begin
         cnt_in = emit ? '0 : cnt_next[RATIO_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RST;
         coef_ff  <= '{b0: B0_RST, b1: B1_RST, b2: B2_RST, a1: A1_RST, a2: A2_RST};
         cnt_ff   <= COUNT_RST;
         xv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         ratio_ff <= ratio_in;
         coef_ff  <= coef_in;
         cnt_ff   <= cnt_in;
         xv_ff    <= xv_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_sample_in;
      end
      if (adv && emit) begin
         ro_ff <= sec_sample;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_sample_out = ro_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(adv && emit && rv_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      adv && emit |=> cnt_ff == '0 && rv_ff)
      else $error("emit did not clear counter or raise valid");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      adv && !emit |=> cnt_ff == RATIO_WIDTH'($past(cnt_ff) + 8'd1))
      else $error("counter did not step");

   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      !adv |=> cnt_ff == $past(cnt_ff))
      else $error("counter moved without a beat");

endmodule

[rtl/bqd_section.sv]
module bqd_section #(
   parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic signed [SAMPLE_WIDTH-1:0]  x,
   input  bqd_pkg::coef_set_type           coefs,
   output logic signed [SAMPLE_WIDTH-1:0]  sample
);
   import bqd_pkg::*;

   localparam int YF = Y_WIDTH - SAMPLE_WIDTH;

   localparam logic signed [63:0] Y_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] Y_MIN   = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] ACC_RND = 64'sd1 <<< (COEF_FRAC_BITS - 4);
   localparam logic signed [32:0] OUT_RND = 33'sd1 <<< (YF - 1);
   localparam logic signed [32:0] S_MAX   = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
   localparam logic signed [32:0] S_MIN   = -(33'sd1 <<< (SAMPLE_WIDTH - 1));

   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [Y_WIDTH-1:0]      y1_ff, y1_in, y2_ff, y2_in;

   logic signed [Y_WIDTH-1:0] xs0, xs1, xs2;
   logic signed [63:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [63:0] acc, acc_sh;
   logic signed [Y_WIDTH-1:0] y;
   logic signed [32:0] y_rnd, o_sh;

   // samples scaled up to the y format
   assign xs0 = {x,     {YF{1'b0}}};
   assign xs1 = {x1_ff, {YF{1'b0}}};
   assign xs2 = {x2_ff, {YF{1'b0}}};

   assign p_b0 = coefs.b0 * xs0;
   assign p_b1 = coefs.b1 * xs1;
   assign p_b2 = coefs.b2 * xs2;
   assign p_a1 = coefs.a1 * y1_ff;
   assign p_a2 = coefs.a2 * y2_ff;

   // each product floors by 3 before the sum
   assign acc = (p_b0 >>> 3) + (p_b1 >>> 3) + (p_b2 >>> 3)
              - (p_a1 >>> 3) - (p_a2 >>> 3) + ACC_RND;
   assign acc_sh = acc >>> (COEF_FRAC_BITS - 3);

   always_comb begin
      if (acc_sh > Y_MAX) begin
         y = Y_MAX[Y_WIDTH-1:0];
      end else if (acc_sh < Y_MIN) begin
         y = Y_MIN[Y_WIDTH-1:0];
      end else begin
         y = acc_sh[Y_WIDTH-1:0];
      end
   end

   assign y_rnd = 33'(y) + OUT_RND;
   assign o_sh  = y_rnd >>> YF;

   always_comb begin
      if (o_sh > S_MAX) begin
         sample = S_MAX[SAMPLE_WIDTH-1:0];
      end else if (o_sh < S_MIN) begin
         sample = S_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         sample = o_sh[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (advance) begin
         x2_in = x1_ff;
         x1_in = x;
         y2_in = y1_ff;
         y1_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

[dv/tb_biquad_lowpass_decimator.sv]
`timescale 1ns / 100ps

module tb_biquad_lowpass_decimator;
   import bqd_pkg::*;

   localparam int SW    = SAMPLE_WIDTH_DEF;
   localparam int CFB   = COEF_FRAC_BITS_DEF;
   localparam int YFRAC = Y_WIDTH - SW;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam longint Y_MAX = (longint'(1) <<< (Y_WIDTH - 1)) - 1;
   localparam longint Y_MIN = -Y_MAX - 1;
   localparam longint S_MAX = (longint'(1) <<< (SW - 1)) - 1;
   localparam longint S_MIN = -S_MAX - 1;

   localparam logic signed [SW-1:0]         X_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]         X_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] C_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] C_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] C_ONE = 32'sd1 <<< CFB;

   localparam int ITEM_TARGET = 650;

   logic                          clock;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic signed [SW-1:0]          req_sample_in  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic signed [SW-1:0]          rsp_sample_out;
   logic                          csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index      = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata      = '0;

   biquad_lowpass_decimator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // filter history, decimation counter and register copies
   logic signed [SW-1:0]      hist_x1   = '0;
   logic signed [SW-1:0]      hist_x2   = '0;
   logic signed [Y_WIDTH-1:0] hist_y1   = '0;
   logic signed [Y_WIDTH-1:0] hist_y2   = '0;
   logic [RATIO_WIDTH-1:0]    dec_count = COUNT_RST;
   logic [RATIO_WIDTH-1:0]    dec_ratio = RATIO_RST;
   coef_set_type              coefs     = {B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};

   logic signed [SW-1:0] sample_feed[$];
   logic signed [SW-1:0] due_outputs[$];

   logic signed [SW-1:0] opening [16] = '{X_MAX, X_MAX, X_MAX, X_MIN, X_MIN, X_MIN,
                                          16'sd0, 16'sd0, 16'sd1, -16'sd1, X_MAX, X_MIN,
                                          X_MAX, X_MIN, 16'sh5555, 16'shAAAA};

   int error_count  = 0;
   int items_sent   = 0;
   int send_wait    = 0;
   int recv_wait    = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 100)
         $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic feed_sample(input logic signed [SW-1:0] s);
      sample_feed = {sample_feed, s};
   endtask

   // one pass of the section, plus the decimation decision
   task automatic filter_and_decimate(input logic signed [SW-1:0] x);
      longint                 acc;
      longint                 yl;
      longint                 ol;
      logic [RATIO_WIDTH:0]   next_count;
      acc  = (longint'(coefs.b0) * (longint'(x) <<< YFRAC)) >>> 3;
      acc += (longint'(coefs.b1) * (longint'(hist_x1) <<< YFRAC)) >>> 3;
      acc += (longint'(coefs.b2) * (longint'(hist_x2) <<< YFRAC)) >>> 3;
      acc -= (longint'(coefs.a1) * longint'(hist_y1)) >>> 3;
      acc -= (longint'(coefs.a2) * longint'(hist_y2)) >>> 3;
      acc += longint'(1) <<< (CFB - 4);
      yl = acc >>> (CFB - 3);
      if (yl > Y_MAX)
         yl = Y_MAX;
      else if (yl < Y_MIN)
         yl = Y_MIN;
      hist_x2 = hist_x1;
      hist_x1 = x;
      hist_y2 = hist_y1;
      hist_y1 = Y_WIDTH'(yl);
      next_count = {1'b0, dec_count} + 1'b1;
      if (next_count >= {1'b0, dec_ratio}) begin
         ol = (yl + (longint'(1) <<< (YFRAC - 1))) >>> YFRAC;
         if (ol > S_MAX)
            ol = S_MAX;
         else if (ol < S_MIN)
            ol = S_MIN;
         due_outputs = {due_outputs, SW'(ol)};
         dec_count = '0;
      end else begin
         dec_count = next_count[RATIO_WIDTH-1:0];
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_DECIM_RATIO: dec_ratio = val[RATIO_WIDTH-1:0];
         REG_COEF_B0:     coefs.b0  = val;
         REG_COEF_B1:     coefs.b1  = val;
         REG_COEF_B2:     coefs.b2  = val;
         REG_COEF_A1:     coefs.a1  = val;
         REG_COEF_A2:     coefs.a2  = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_ratio(input logic [RATIO_WIDTH-1:0] r);
      // upper data bits are junk, only the low byte counts
      write_reg(REG_DECIM_RATIO, {24'($urandom), r});
   endtask

   task automatic load_coefs(input coef_set_type c);
      write_reg(REG_COEF_B0, c.b0);
      write_reg(REG_COEF_B1, c.b1);
      write_reg(REG_COEF_B2, c.b2);
      write_reg(REG_COEF_A1, c.a1);
      write_reg(REG_COEF_A2, c.a2);
   endtask

   function automatic logic signed [COEF_WIDTH-1:0] pick_extreme_coef();
      case ($urandom_range(0, 4))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3:       return C_ONE;
         default: return -C_ONE;
      endcase
   endfunction

   function automatic coef_set_type pick_coefs(input int kind);
      coef_set_type c;
      case (kind)
         0: c = {B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
         1: c = {$urandom, $urandom, $urandom, $urandom, $urandom};
         2: begin
            // modest gains, mostly stays out of saturation
            c.b0 = $signed($urandom) >>> 4;
            c.b1 = $signed($urandom) >>> 4;
            c.b2 = $signed($urandom) >>> 4;
            c.a1 = $signed($urandom) >>> 2;
            c.a2 = $signed($urandom) >>> 4;
         end
         default: begin
            c.b0 = pick_extreme_coef();
            c.b1 = pick_extreme_coef();
            c.b2 = pick_extreme_coef();
            c.a1 = pick_extreme_coef();
            c.a2 = pick_extreme_coef();
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [SW-1:0] pick_sample(input int flavor);
      case (flavor)
         0: return SW'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0:       return X_MAX;
               1:       return X_MIN;
               2:       return '0;
               3:       return 16'sd1;
               default: return -16'sd1;
            endcase
         end
         2: return $signed(SW'($urandom)) >>> 10;
         default: begin
            if ($urandom_range(0, 1) == 0)
               return X_MAX - SW'($urandom_range(0, 255));
            return X_MIN + SW'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic int draw_wait(input bit on);
      if (!on)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   // block is idle: nothing queued or in flight, then a few cycles of slack
   task automatic wait_drained();
      do
         @(posedge clock);
      while (sample_feed.size() != 0 || req_valid || due_outputs.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_phase(input int n, input int flavor);
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      repeat (n) feed_sample(pick_sample(flavor));
      items_sent += n;
      wait_drained();
   endtask

   // input side driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait  = draw_wait(send_idle_on);
      end else begin
         if (req_valid && !req_stall)
            filter_and_decimate(req_sample_in);
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (sample_feed.size() != 0) begin
               req_valid     <= 1'b1;
               req_sample_in <= sample_feed.pop_front();
               send_wait      = draw_wait(send_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // output side monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_outputs.size() == 0) begin
               report_mismatch($sformatf("output beat %0d with nothing due", rsp_sample_out));
            end else if (rsp_sample_out !== due_outputs[0]) begin
               report_mismatch($sformatf("sample_out got %0d, want %0d",
                                         rsp_sample_out, due_outputs[0]));
               void'(due_outputs.pop_front());
            end else begin
               void'(due_outputs.pop_front());
            end
            recv_wait = draw_wait(recv_idle_on);
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait > 0);
      end
   end

   initial begin
      coef_set_type c;
      int           r;
      int           n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ratio 10, count starts at 8
      foreach (opening[i]) feed_sample(opening[i]);
      items_sent += 16;
      wait_drained();

      // ratio zero, gain extremes drive both saturations
      write_ratio(8'd0);
      load_coefs({C_MAX, C_MIN, 32'sd0, 32'sd0, 32'sd0});
      write_reg(REG_SPARE_6, $urandom);
      write_reg(REG_SPARE_7, $urandom);
      feed_sample(X_MAX);
      feed_sample(X_MAX);
      feed_sample(X_MIN);
      feed_sample(X_MIN);
      feed_sample(16'sd0);
      feed_sample(X_MAX);
      feed_sample(X_MIN);
      feed_sample(16'sd1);
      items_sent += 8;
      wait_drained();

      // ratio one with runaway feedback
      write_ratio(8'd1);
      load_coefs({C_ONE, 32'sd0, 32'sd0, C_MIN, C_MAX});
      run_phase(8, 1);

      // widest ratio, then drop the ratio below the running count
      write_ratio(8'd255);
      load_coefs(pick_coefs(0));
      run_phase(300, 0);
      write_ratio(8'd2);
      run_phase(20, 0);

      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       write_ratio(8'd0);
            1:       write_ratio(8'd1);
            2:       write_ratio(8'd2);
            3:       write_ratio(8'd255);
            default: write_ratio(8'($urandom_range(2, 12)));
         endcase
         if ($urandom_range(0, 2) != 0) begin
            c = pick_coefs($urandom_range(0, 3));
            load_coefs(c);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
         n = (r == 3) ? 260 : int'($urandom_range(20, 60));
         if (n > ITEM_TARGET - items_sent)
            n = ITEM_TARGET - items_sent;
         run_phase(n, $urandom_range(0, 3));
      end

      if (error_count == 0)
         $display("tb_biquad_lowpass_decimator: done, clean");
      else
         $display("tb_biquad_lowpass_decimator: done, errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_biquad_lowpass_decimator: done, errors");
      $finish;
   end

endmodule
